[hw/rtl/kbh_pkg.sv]
// ----------------------------------------------------------------------------
// kbh_pkg
// Shared types and constants for the key-to-bucket hash block.
// ----------------------------------------------------------------------------
package kbh_pkg;

  localparam int HASH_W      = 32;
  localparam int KEY_W       = 64;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 17;
  localparam int BUCKET_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(HASH_W);

  localparam logic [COUNT_W-1:0] MAX_BUCKETS  = COUNT_W'(65536);
  localparam logic [COUNT_W-1:0] RESET_BUCKETS = COUNT_W'(16);

  // key kinds; the high bit selects text
  localparam logic [KIND_W-1:0] KIND_INT32 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INT64 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KIND         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_beat_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } queue_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

[hw/rtl/key_to_bucket_hash.sv]
// Path: a finished key's hash is written into the hash queue, popped into the bit-serial
// modulo divider, held in BK_DONE until the output register is free, then loaded there.
// Input beats are taken one per cycle while the queue is not full; the divider works on
// one key at a time and sets the sustained key rate. A four-entry hash queue lets the
// front keep accepting while the divider works. Reset clears the text accumulator, the
// queue and the output register, and sets key kind to int32 and bucket count to 16.
// ----------------------------------------------------------------------------
// key_to_bucket_hash
// Maps int32, int64 or text keys to a 32-bit hash and a bucket index.
// ----------------------------------------------------------------------------
module key_to_bucket_hash import kbh_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [KEY_W-1:0]            s_tdata,   // key_value
  input  logic                        s_tuser,   // byte_present
  input  logic                        s_tlast,   // last
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [HASH_W+BUCKET_W-1:0]  m_tdata,   // hash_value[31:0], bucket[47:32]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COUNT_W-1:0]          cfg_data
);

  logic [KIND_W-1:0]  kind;
  logic [COUNT_W-1:0] bucket_count;
  logic               beat_take;
  logic               queue_full;
  logic               pop;
  hash_beat_t         push;
  queue_head_t        head;

  assign cfg_ready = 1'b1;
  assign s_tready  = !queue_full;
  assign beat_take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind         <= KIND_INT32;
      bucket_count <= RESET_BUCKETS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KIND:         kind         <= cfg_data[KIND_W-1:0];
        CFG_BUCKET_COUNT: bucket_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  kbh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .beat_take    (beat_take),
    .key_value    (s_tdata),
    .byte_present (s_tuser),
    .last         (s_tlast),
    .push         (push)
  );

  kbh_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  kbh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule

[hw/rtl/kbh_front.sv]
// ----------------------------------------------------------------------------
// kbh_front
// Accepts key beats, forms the 32-bit hash and pushes finished hashes.
// ----------------------------------------------------------------------------
module kbh_front import kbh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [KIND_W-1:0]   kind,
  input  logic                beat_take,
  input  logic [KEY_W-1:0]    key_value,
  input  logic                byte_present,
  input  logic                last,
  output hash_beat_t          push
);

  logic [HASH_W-1:0] text_acc;
  logic [HASH_W-1:0] text_acc_next;
  logic [HASH_W-1:0] text_sum;
  logic [HASH_W-1:0] hash;
  logic              is_text;
  logic              emit;

  assign is_text = kind[1];

  // acc * 31 as (acc << 5) - acc, modulo 2^32
  assign text_sum = ((text_acc << 5) - text_acc)
                  + {{(HASH_W-BYTE_W){1'b0}}, key_value[BYTE_W-1:0]};

  always_comb begin
    text_acc_next = byte_present ? text_sum : text_acc;
    emit          = !is_text || last;
    unique case (kind)
      KIND_INT32: hash = key_value[HASH_W-1:0];
      KIND_INT64: hash = key_value[HASH_W-1:0] ^ key_value[KEY_W-1:HASH_W];
      default:    hash = text_acc_next;
    endcase
    push.valid = beat_take && emit;
    push.hash  = hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_acc <= '0;
    end else if (beat_take && is_text) begin
      // clear once the key is finished
      text_acc <= last ? '0 : text_acc_next;
    end
  end

endmodule

[hw/rtl/kbh_queue.sv]
// ----------------------------------------------------------------------------
// kbh_queue
// Small FIFO of finished hashes between the front and the divider.
// ----------------------------------------------------------------------------
module kbh_queue import kbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  hash_beat_t  push,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  logic [HASH_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full       = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.hash  = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/kbh_back.sv]
// ----------------------------------------------------------------------------
// kbh_back
// Reduces each queued hash modulo the bucket count, one quotient bit per
// cycle, and holds the result in the output register.
// ----------------------------------------------------------------------------
module kbh_back import kbh_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [COUNT_W-1:0]           bucket_count,
  input  queue_head_t                  head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [HASH_W+BUCKET_W-1:0]   out_data
);

  back_state_t          state;
  back_state_t          state_next;
  logic [HASH_W-1:0]    hash;
  logic [HASH_W-1:0]    shift;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   rem_next;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] step;
  logic                 slot_free;
  logic                 load_out;
  logic                 start;
  logic [BUCKET_W-1:0]  bucket;

  assign divisor   = (bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : bucket_count;
  assign slot_free = !out_valid || out_ready;
  assign trial     = {rem, shift[HASH_W-1]};
  assign rem_next  = (trial >= {1'b0, divisor}) ? COUNT_W'(trial - {1'b0, divisor})
                                                : trial[COUNT_W-1:0];
  assign bucket    = (divisor == '0) ? '0 : rem[BUCKET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          start      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == DIV_CNT_W'(HASH_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        // hold until the output register can take the beat
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash  <= head.hash;
      shift <= head.hash;
      rem   <= '0;
      step  <= '0;
    end else if (state == BK_DIV) begin
      shift <= shift << 1;
      rem   <= rem_next;
      step  <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {bucket, hash};
    end
  end

endmodule

[sim/tb_key_to_bucket_hash.sv]
// ----------------------------------------------------------------------------
// tb_key_to_bucket_hash
// Drives int32, int64 and text keys through the hash block under random
// bus gaps and back-pressure, predicts each key's hash and bucket, and
// compares every result beat in order against the predicted value.
// ----------------------------------------------------------------------------
module tb_key_to_bucket_hash;
  import kbh_pkg::*;

  localparam logic [HASH_W-1:0]    HASH_MULT     = 32'd31;
  localparam logic [KIND_W-1:0]    KIND_TEXT_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 60;

  class hash_bucket_board;
    logic [KIND_W-1:0]          kind;
    logic [COUNT_W-1:0]         count;
    logic [HASH_W-1:0]          text_hash;
    logic [HASH_W+BUCKET_W-1:0] awaited[$];
    int                         errors;

    function void clear();
      kind = KIND_INT32;
      count = RESET_BUCKETS;
      text_hash = '0;
      awaited.delete();
      errors = 0;
    endfunction

    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] word);
      case (idx)
        CFG_KIND: begin
          kind = word[KIND_W-1:0];
        end
        CFG_BUCKET_COUNT: begin
          count = word;
        end
        default: begin
        end
      endcase
    endfunction

    function void push_hash(logic [HASH_W-1:0] hash);
      logic [COUNT_W-1:0] divisor;
      logic [HASH_W-1:0]  rem;
      divisor = (count > MAX_BUCKETS) ? MAX_BUCKETS : count;
      rem = (divisor == '0) ? '0 : hash % HASH_W'(divisor);
      awaited.insert(awaited.size(), {rem[BUCKET_W-1:0], hash});
    endfunction

    function void take_key_beat(logic [KEY_W-1:0] key, logic present, logic fin);
      if (kind == KIND_INT32) begin
        push_hash(key[HASH_W-1:0]);
      end else if (kind == KIND_INT64) begin
        push_hash(key[HASH_W-1:0] ^ key[KEY_W-1:HASH_W]);
      end else begin
        if (present)
          text_hash = text_hash * HASH_MULT + HASH_W'(key[BYTE_W-1:0]);
        if (fin) begin
          push_hash(text_hash);
          text_hash = '0;
        end
      end
    endfunction

    function void take_result_beat(logic [HASH_W+BUCKET_W-1:0] beat);
      logic [HASH_W+BUCKET_W-1:0] want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (beat[HASH_W-1:0] !== want[HASH_W-1:0]) begin
        $display("%0t: hash_value expected %h actual %h", $time,
                 want[HASH_W-1:0], beat[HASH_W-1:0]);
        errors++;
      end
      if (beat[HASH_W +: BUCKET_W] !== want[HASH_W +: BUCKET_W]) begin
        $display("%0t: bucket expected %0d actual %0d", $time,
                 want[HASH_W +: BUCKET_W], beat[HASH_W +: BUCKET_W]);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [KEY_W-1:0]           s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       s_tlast = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [HASH_W+BUCKET_W-1:0] m_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COUNT_W-1:0]         cfg_data = '0;

  hash_bucket_board board = new();
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int items_sent = 0;

  key_to_bucket_hash DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // mostly short gaps, a few long ones; none during a burst stretch
  function automatic int idle_len(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // result side: check accepted beats, then pick the next ready pattern
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        board.take_result_beat(m_tdata);
      if (hold == 0) begin
        hold = m_tready ? idle_len(rx_burst) : 0;
        if (hold > 0) begin
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          hold = $urandom_range(1, 16);
        end
      end
      hold--;
    end
  end

  task automatic send_beat(input logic [KEY_W-1:0] key, input logic present,
                           input logic fin);
    int gap;
    gap = idle_len(tx_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= present;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    // text beats with no byte and no last do nothing; leave them out of the count
    if (!board.kind[1] || present || fin)
      items_sent++;
    board.take_key_beat(key, present, fin);
  endtask

  task automatic wait_cfg_beat();
    do @(posedge clk); while (!cfg_ready);
    board.take_config(cfg_index, cfg_data);
  endtask

  task automatic program_block(input logic [KIND_W-1:0] kind,
                               input logic [COUNT_W-1:0] count, input bit with_spare);
    logic [COUNT_W-1:0] word;
    word = COUNT_W'($urandom);
    word[KIND_W-1:0] = kind;
    cfg_valid <= 1'b1;
    if (with_spare) begin
      cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
      cfg_data  <= COUNT_W'($urandom);
      wait_cfg_beat();
    end
    cfg_index <= CFG_KIND;
    cfg_data  <= word;
    wait_cfg_beat();
    cfg_index <= CFG_BUCKET_COUNT;
    cfg_data  <= count;
    wait_cfg_beat();
    cfg_valid <= 1'b0;
  endtask

  // drop valid, let every awaited result out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_int_key();
    logic [HASH_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return {w, w};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    case ($urandom_range(0, 5))
      0: return KIND_INT32;
      1: return KIND_INT64;
      5: return KIND_TEXT_ALT;
      default: return KIND_TEXT;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return COUNT_W'(1);
    if (r == 2) return MAX_BUCKETS;
    if (r == 3) return COUNT_W'($urandom_range(65537, 131071));
    if (r < 10) return COUNT_W'($urandom_range(1, 16));
    if (r < 15) return COUNT_W'($urandom_range(17, 1000));
    return COUNT_W'($urandom_range(1, 65536));
  endfunction

  // a well-formed key most of the time; sometimes stray empty beats,
  // a trailing empty last beat, or a key cut off with no last
  task automatic send_text_key();
    int r, len, ending;
    r = $urandom_range(0, 19);
    len = (r == 0) ? 0 : (r < 18) ? $urandom_range(1, 8) : $urandom_range(20, 40);
    ending = $urandom_range(0, 11);
    if (len == 0) begin
      send_beat({$urandom, $urandom}, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_beat({$urandom, $urandom}, 1'b0, 1'b0);
      send_beat({$urandom, $urandom}, 1'b1, (i == len - 1) && ending > 2);
    end
    if (ending == 1 || ending == 2)
      send_beat({$urandom, $urandom}, 1'b0, 1'b1);
  endtask

  initial begin
    int phase_end;
    board.clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: int32 keys, 16 buckets; upper key bits must be ignored
    send_beat(64'h0, 1'b0, 1'b0);
    send_beat(64'hA5A5_0000_FFFF_FFFF, 1'b1, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_beat(64'hFFFF_FFFF_8000_0001, 1'b1, 1'b0);
    wait_idle();
    program_block(KIND_INT64, MAX_BUCKETS, 1'b1);
    send_beat(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0);
    send_beat(64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_beat(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1);
    wait_idle();
    // one bucket; short text key, empty key, stray empty beat, empty last beat
    program_block(KIND_TEXT, COUNT_W'(1), 1'b0);
    send_beat(64'hFFFF_0000_0000_0061, 1'b1, 1'b0);
    send_beat(64'h0000_0000_0000_0062, 1'b1, 1'b1);
    send_beat(64'h0, 1'b0, 1'b1);
    send_beat(64'h0000_0000_0000_00FF, 1'b1, 1'b0);
    send_beat(64'h0000_0000_0000_0055, 1'b0, 1'b0);
    send_beat(64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b1);
    send_beat(64'h0000_0000_0000_0041, 1'b1, 1'b0);
    send_beat(64'h0000_0000_0000_00AA, 1'b0, 1'b1);
    wait_idle();
    // unused kind code reads as text; zero buckets gives bucket 0
    program_block(KIND_TEXT_ALT, '0, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b0);
    send_beat(64'h0000_0000_0000_007F, 1'b1, 1'b1);
    wait_idle();
    // bucket count past the top saturates
    program_block(KIND_TEXT, '1, 1'b0);
    repeat (3) send_beat(64'h0000_0000_0000_00FF, 1'b1, 1'b0);
    send_beat(64'h0000_0000_0000_00FF, 1'b1, 1'b1);
    wait_idle();
    program_block(KIND_INT32, COUNT_W'(65537), 1'b0);
    send_beat(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0);
    send_beat({$urandom, $urandom}, 1'b1, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      program_block(pick_kind(), pick_count(), $urandom_range(0, 3) == 0);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(10, 60);
      while (items_sent < phase_end) begin
        if (board.kind[1])
          send_text_key();
        else
          send_beat(rand_int_key(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
